// ===== hw/rtl/cfbx_pkg.sv =====
// cfbx_pkg: constants and types for the command frame builder
// frame marker bytes, header overhead and the per-item step codes
// no dependencies
package cfbx_pkg;

    localparam logic [7:0] FRAME_HEAD     = 8'h73;
    localparam logic [7:0] FRAME_CNTL     = 8'h23;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd5;

    typedef logic [2:0] t_step;

    // which byte of the current request goes out next
    localparam t_step STEP_HEAD = 3'd0;
    localparam t_step STEP_LEN  = 3'd1;
    localparam t_step STEP_CNTL = 3'd2;
    localparam t_step STEP_CMD  = 3'd3;
    localparam t_step STEP_DATA = 3'd4;
    localparam t_step STEP_CHK  = 3'd5;

endpackage

// ===== hw/rtl/command_frame_builder_xor_core.sv =====
// command_frame_builder_xor_core: builds command frames with an xor checksum
// uses cfbx_pkg for marker bytes and step codes
//
// usage: requests enter on i_in_valid / o_in_ready. a start request
// (i_req_type = 0) opens a frame and puts out 0x73, the length byte
// (data length + 5, low 8 bits), 0x23 and the command. each data request
// (i_req_type = 1) puts out its byte; after the last counted data byte the
// checksum byte (xor of all earlier frame bytes) follows with o_frame_end
// high. a zero-length start puts its checksum right after the header. data
// outside a frame is dropped; a start inside a frame abandons the old one.
// bytes leave on o_out_valid / i_out_ready from an output register.
// the request is registered first; its first byte then goes into the output
// register as soon as the output slot is free.
// throughput: one output byte per cycle while the receiver takes them, set
// by the single output register; a data request puts out one byte (two when
// it closes the frame), a start puts out four (five for a zero-length frame)
// and a dropped request none. when the receiver stalls, the output byte holds
// and a request in work waits, so o_in_ready stays low until the slot frees;
// an idle core still takes requests and drops still go ahead. reset clears
// the checksum, the byte count and the open-frame, busy and output valid flags.
module command_frame_builder_xor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_command,
    input  logic [15:0] i_data_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);

    // request in work
    logic                r_busy,      n_busy;
    cfbx_pkg::t_step     r_step,      n_step;
    logic [7:0]          r_command;
    logic [15:0]         r_data_length;
    logic [7:0]          r_data_byte;

    // frame state
    logic [7:0]          r_xor,       n_xor;
    logic [15:0]         r_bytes_left, n_bytes_left;
    logic                r_in_frame,  n_in_frame;

    // output register
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_end;

    logic                w_slot;
    logic                w_drop;
    logic                w_emit;
    logic                w_last;
    logic                w_take;
    logic [7:0]          w_byte;
    logic [7:0]          w_len_byte;

    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_len_byte = r_data_length[7:0] + cfbx_pkg::FRAME_OVERHEAD;
    assign w_drop     = r_busy && (r_step == cfbx_pkg::STEP_DATA)
                        && (!r_in_frame || (r_bytes_left == 16'd0));
    assign w_emit     = r_busy && !w_drop && w_slot;
    assign o_in_ready = !r_busy || w_drop || (w_emit && w_last);
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        w_byte       = r_xor;
        w_last       = 1'b1;
        n_step       = r_step;
        n_xor        = r_xor;
        n_bytes_left = r_bytes_left;
        n_in_frame   = r_in_frame;
        unique case (r_step)
            cfbx_pkg::STEP_HEAD: begin
                w_byte = cfbx_pkg::FRAME_HEAD;
                w_last = 1'b0;
                n_step = cfbx_pkg::STEP_LEN;
                n_xor  = cfbx_pkg::FRAME_HEAD;
            end
            cfbx_pkg::STEP_LEN: begin
                w_byte = w_len_byte;
                w_last = 1'b0;
                n_step = cfbx_pkg::STEP_CNTL;
                n_xor  = r_xor ^ w_len_byte;
            end
            cfbx_pkg::STEP_CNTL: begin
                w_byte = cfbx_pkg::FRAME_CNTL;
                w_last = 1'b0;
                n_step = cfbx_pkg::STEP_CMD;
                n_xor  = r_xor ^ cfbx_pkg::FRAME_CNTL;
            end
            cfbx_pkg::STEP_CMD: begin
                w_byte       = r_command;
                w_last       = (r_data_length != 16'd0);
                n_step       = cfbx_pkg::STEP_CHK;
                n_xor        = r_xor ^ r_command;
                n_bytes_left = r_data_length;
                n_in_frame   = 1'b1;
            end
            cfbx_pkg::STEP_DATA: begin
                w_byte       = r_data_byte;
                w_last       = (r_bytes_left != 16'd1);
                n_step       = cfbx_pkg::STEP_CHK;
                n_xor        = r_xor ^ r_data_byte;
                n_bytes_left = r_bytes_left - 16'd1;
            end
            default: begin
                // checksum byte closes the frame
                w_byte       = r_xor;
                w_last       = 1'b1;
                n_xor        = 8'h00;
                n_bytes_left = 16'd0;
                n_in_frame   = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        if (w_drop || (w_emit && w_last)) begin
            n_busy = 1'b0;
        end
        if (w_take) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_step       <= cfbx_pkg::STEP_HEAD;
            r_xor        <= 8'h00;
            r_bytes_left <= 16'd0;
            r_in_frame   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_emit) begin
                r_xor        <= n_xor;
                r_bytes_left <= n_bytes_left;
                r_in_frame   <= n_in_frame;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
            if (w_take) begin
                r_step <= i_req_type ? cfbx_pkg::STEP_DATA : cfbx_pkg::STEP_HEAD;
            end else if (w_emit) begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_command     <= i_command;
            r_data_length <= i_data_length;
            r_data_byte   <= i_data_byte;
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_end  <= (r_step == cfbx_pkg::STEP_CHK);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_end;

endmodule
